/* rtl/core/bisv_pkg.sv */
package bisv_pkg;

    typedef struct packed {
        logic [7:0] image_byte;
        logic       last;
        logic       update_active;
        logic       update_pending;
        logic       raw_command_seen;
    } item_t;

    typedef struct packed {
        logic       boot_ok;
        logic [2:0] status;
    } result_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_UPDATING   = 3'd1,
        ST_PENDING    = 3'd2,
        ST_NO_SIG     = 3'd3,
        ST_BAD_LENGTH = 3'd4,
        ST_BOARD      = 3'd5,
        ST_CRC        = 3'd6,
        ST_NO_RAW     = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_RECORD = 2'd1,
        PH_AFTER  = 2'd2
    } phase_t;

    typedef enum logic {
        CFG_BOARD_NAME     = 1'b0,
        CFG_BOARD_NAME_LEN = 1'b1
    } cfg_index_t;

    localparam int          CFG_DATA_W = 64;
    localparam int          NAME_LEN_W = 4;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    // byte i of the marker sits in bits 8i+7..8i
    localparam logic [63:0] MAGIC_SEQ  = 64'hAFCEE5A0_68F058E6;
    localparam logic [5:0]  REC_BYTES      = 6'd48;
    localparam logic [5:0]  REC_LAST       = 6'd47;
    localparam logic [5:0]  LEN_AT         = 6'd8;
    localparam logic [5:0]  CRC_BEFORE_AT  = 6'd12;
    localparam logic [5:0]  CRC_AFTER_AT   = 6'd16;
    localparam logic [5:0]  NAME_FIELD_AT  = 6'd20;
    localparam logic [5:0]  NAME_FIELD_LEN = 6'd16;

    // reflected CRC-32, one byte, eight bit steps
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/core/bisv_scan.sv */
module bisv_scan import bisv_pkg::*; #(
    parameter int REGION_BYTES = 112640,
    parameter int NAME_BYTES   = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  item_t                 item,
    input  logic [CFG_DATA_W-1:0] board_name,
    input  logic [NAME_LEN_W-1:0] board_name_len,
    output status_t               status
);

    localparam int POS_W      = $clog2(REGION_BYTES + 1);
    localparam int NAME_IDX_W = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int NCMP       = (NAME_BYTES < 8) ? NAME_BYTES : 8;

    logic [POS_W-1:0] pos_reg, pos_step, pos_next;
    phase_t           phase_reg, phase_step, phase_next;
    logic [31:0]      crc_reg, crc_step, crc_next;
    logic [7:0]       recent_reg [8];
    logic [7:0]       recent_next [8];
    logic [POS_W-1:0] offset_reg, offset_next;
    logic [31:0]      crc_before_reg, crc_before_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      stated_before_reg, stated_before_next;
    logic [31:0]      stated_after_reg, stated_after_next;
    logic [7:0]       name_reg [NAME_BYTES];
    logic [7:0]       name_next [NAME_BYTES];

    logic             active;
    logic             hit;
    logic             clear;
    logic [POS_W-1:0] rel;
    logic [5:0]       rel6;
    logic [7:0]       crc_in_byte;
    logic [31:0]      crc_calc;
    logic             name_bad;

    assign active      = pos_reg < POS_W'(REGION_BYTES);
    assign rel         = pos_reg - offset_reg;
    assign rel6        = rel[5:0];
    assign crc_in_byte = (phase_reg == PH_SEARCH) ? recent_reg[7] : item.image_byte;
    assign crc_calc    = crc32_byte(crc_reg, crc_in_byte);
    assign clear       = step && item.last;

    // window after the shift: oldest byte at recent[7], new byte at recent[0]
    always_comb
    begin
        hit = (pos_reg >= POS_W'(7)) && (item.image_byte == MAGIC_SEQ[63:56]);
        for (int i = 0; i < 7; i++)
        begin
            if (recent_reg[6 - i] != MAGIC_SEQ[8*i +: 8])
            begin
                hit = 1'b0;
            end
        end
    end

    always_comb
    begin
        phase_step = phase_reg;
        if (step && active)
        begin
            case (phase_reg)
                PH_SEARCH:
                begin
                    if (hit)
                    begin
                        phase_step = PH_RECORD;
                    end
                end
                PH_RECORD:
                begin
                    if (rel6 >= REC_LAST)
                    begin
                        phase_step = PH_AFTER;
                    end
                end
                PH_AFTER:  phase_step = PH_AFTER;
                default:   phase_step = PH_SEARCH;
            endcase
        end
    end

    assign phase_next = clear ? PH_SEARCH : phase_step;

    always_comb
    begin
        pos_step           = pos_reg;
        crc_step           = crc_reg;
        recent_next        = recent_reg;
        offset_next        = offset_reg;
        crc_before_next    = crc_before_reg;
        len_next           = len_reg;
        stated_before_next = stated_before_reg;
        stated_after_next  = stated_after_reg;
        name_next          = name_reg;
        if (step && active)
        begin
            pos_step = pos_reg + POS_W'(1);
            case (phase_reg)
                PH_SEARCH:
                begin
                    if (pos_reg >= POS_W'(8))
                    begin
                        crc_step = crc_calc;
                    end
                    for (int i = 7; i > 0; i--)
                    begin
                        recent_next[i] = recent_reg[i - 1];
                    end
                    recent_next[0] = item.image_byte;
                    if (hit)
                    begin
                        offset_next     = pos_reg - POS_W'(7);
                        crc_before_next = crc_step;
                    end
                end
                PH_RECORD:
                begin
                    if (rel6 >= LEN_AT && rel6 < CRC_BEFORE_AT)
                    begin
                        len_next[{rel6[1:0], 3'b000} +: 8] = item.image_byte;
                    end
                    else if (rel6 >= CRC_BEFORE_AT && rel6 < CRC_AFTER_AT)
                    begin
                        stated_before_next[{rel6[1:0], 3'b000} +: 8] = item.image_byte;
                    end
                    else if (rel6 >= CRC_AFTER_AT && rel6 < NAME_FIELD_AT)
                    begin
                        stated_after_next[{rel6[1:0], 3'b000} +: 8] = item.image_byte;
                    end
                    else if (rel6 >= NAME_FIELD_AT && rel6 < NAME_FIELD_AT + NAME_FIELD_LEN &&
                             (rel6 - NAME_FIELD_AT) < 6'(NAME_BYTES))
                    begin
                        name_next[NAME_IDX_W'(rel6 - NAME_FIELD_AT)] = item.image_byte;
                    end
                    if (rel6 >= REC_LAST)
                    begin
                        crc_step = 32'd0;
                    end
                end
                PH_AFTER:
                begin
                    if (32'(pos_reg) < len_reg)
                    begin
                        crc_step = crc_calc;
                    end
                end
                default: ;
            endcase
        end
    end

    assign pos_next = clear ? '0 : pos_step;
    assign crc_next = clear ? 32'd0 : crc_step;

    always_comb
    begin
        name_bad = 1'b0;
        for (int i = 0; i < NCMP; i++)
        begin
            if (NAME_LEN_W'(i) < board_name_len && board_name[8*i +: 8] != name_next[i])
            begin
                name_bad = 1'b1;
            end
        end
    end

    // verdict on the state as it stands once this beat is taken in
    always_comb
    begin
        if (item.update_active)
        begin
            status = ST_UPDATING;
        end
        else if (item.update_pending)
        begin
            status = ST_PENDING;
        end
        else if (phase_step == PH_SEARCH || offset_next[1:0] != 2'd0)
        begin
            status = ST_NO_SIG;
        end
        else if (phase_step != PH_AFTER || len_next > 32'(REGION_BYTES) ||
                 len_next < 32'(offset_next) + 32'(REC_BYTES) || len_next > 32'(pos_step))
        begin
            status = ST_BAD_LENGTH;
        end
        else if (name_bad)
        begin
            status = ST_BOARD;
        end
        else if (crc_before_next != stated_before_next || crc_step != stated_after_next)
        begin
            status = ST_CRC;
        end
        else if (!item.raw_command_seen)
        begin
            status = ST_NO_RAW;
        end
        else
        begin
            status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_SEARCH;
            crc_reg   <= 32'd0;
        end
        else
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
        end
    end

    // record fields are always rewritten before they are read
    always_ff @(posedge clk)
    begin
        recent_reg        <= recent_next;
        offset_reg        <= offset_next;
        crc_before_reg    <= crc_before_next;
        len_reg           <= len_next;
        stated_before_reg <= stated_before_next;
        stated_after_reg  <= stated_after_next;
        name_reg          <= name_next;
    end

    a_record_span: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_RECORD |-> rel < POS_W'(REC_BYTES))
        else $error("record offset walked past the record");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(REGION_BYTES))
        else $error("byte position beyond region");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> pos_reg == '0 && phase_reg == PH_SEARCH && crc_reg == 32'd0)
        else $error("state not cleared after verdict");

endmodule

/* rtl/core/boot_image_signature_verifier.sv */
// Boot image signature check. Flash bytes of the application region enter one beat per
// clock on item; the beat flagged last yields one verdict on result (status plus boot_ok),
// registered and valid from the edge at which that beat leaves the input register.
// Sustained rate is one byte per cycle, set by the byte-wide CRC-32 update (eight bit
// steps unrolled) in front of the scan state registers. A final beat waits only while an
// earlier verdict is still untaken on result; other beats keep flowing. The marker search,
// record capture and both CRCs restart after each verdict. board_name and board_name_len
// must be written through cfg only while the stream is idle; the block does not enforce
// this. cfg is always ready.
module boot_image_signature_verifier import bisv_pkg::*; #(
    parameter int REGION_BYTES = 112640,
    parameter int NAME_BYTES   = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic                  item_valid_reg, item_valid_next;
    item_t                 item_reg;
    logic                  result_valid_reg, result_valid_next;
    result_t               result_reg;
    logic [CFG_DATA_W-1:0] board_name_reg;
    logic [NAME_LEN_W-1:0] board_name_len_reg;
    logic                  advance;
    status_t               status;

    assign advance    = item_valid_reg && (!item_reg.last || !result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;
    assign cfg_ready  = 1'b1;

    assign item_valid_next   = (item_valid && item_ready) ? 1'b1 :
                               (advance ? 1'b0 : item_valid_reg);
    assign result_valid_next = (advance && item_reg.last) ? 1'b1 :
                               (result_ready ? 1'b0 : result_valid_reg);

    bisv_scan #(
        .REGION_BYTES (REGION_BYTES),
        .NAME_BYTES   (NAME_BYTES)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .item           (item_reg),
        .board_name     (board_name_reg),
        .board_name_len (board_name_len_reg),
        .status         (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg     <= 1'b0;
            result_valid_reg   <= 1'b0;
            board_name_reg     <= '0;
            board_name_len_reg <= '0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BOARD_NAME:     board_name_reg     <= cfg_data;
                    CFG_BOARD_NAME_LEN: board_name_len_reg <= cfg_data[NAME_LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (advance && item_reg.last)
        begin
            result_reg.boot_ok <= (status == ST_OK);
            result_reg.status  <= status;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_ok_matches: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> result_reg.boot_ok == (result_reg.status == ST_OK))
        else $error("boot_ok disagrees with status");

    a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !advance) |=> item_valid_reg && $stable(item_reg))
        else $error("stalled beat lost from input register");

    a_verdict_out: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.last) |=> result_valid_reg)
        else $error("final beat gave no verdict");

endmodule

/* verif/bisv_verdict_checker.sv */
`timescale 1ns / 100ps

module bisv_verdict_checker import bisv_pkg::*; #(
    parameter int REGION_BYTES = 112640,
    parameter int NAME_BYTES   = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_ready,
    input  item_t                 item,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  result_t               result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    verdicts_due
);

    // board registers as last written
    logic [63:0]           exp_name;
    logic [NAME_LEN_W-1:0] exp_name_len;

    // scan state
    logic [16:0] pos;
    logic [7:0]  hist [8];
    phase_t      phase;
    logic [16:0] rec_off;
    logic [31:0] crc_run;
    logic [31:0] crc_pre;
    logic [31:0] len_st;
    logic [31:0] crc_pre_st;
    logic [31:0] crc_post_st;
    logic [7:0]  rec_name [NAME_BYTES];

    result_t pending_verdicts [$];
    int      errors = 0;

    function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] data);
        logic [31:0] c;
        c = acc ^ {24'd0, data};
        repeat (8)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    task automatic restart_scan();
        pos         = '0;
        phase       = PH_SEARCH;
        rec_off     = '0;
        crc_run     = '0;
        crc_pre     = '0;
        len_st      = '0;
        crc_pre_st  = '0;
        crc_post_st = '0;
        for (int i = 0; i < 8; i++)
        begin
            hist[i] = '0;
        end
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            rec_name[i] = '0;
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        logic [16:0] r;
        if (phase == PH_SEARCH)
        begin
            // the byte falling out of the window belongs to the pre-record span
            if (pos >= 17'd8)
                crc_run = crc_step(crc_run, hist[7]);
            for (int i = 7; i > 0; i--)
            begin
                hist[i] = hist[i-1];
            end
            hist[0] = b;
            if (pos >= 17'd7 && {hist[0], hist[1], hist[2], hist[3],
                                 hist[4], hist[5], hist[6], hist[7]} == MAGIC_SEQ)
            begin
                rec_off = pos - 17'd7;
                crc_pre = crc_run;
                phase   = PH_RECORD;
            end
        end
        else if (phase == PH_RECORD)
        begin
            r = pos - rec_off;
            if (r >= LEN_AT && r < CRC_BEFORE_AT)
                len_st = len_st | ({24'd0, b} << (8 * (r - LEN_AT)));
            else if (r >= CRC_BEFORE_AT && r < CRC_AFTER_AT)
                crc_pre_st = crc_pre_st | ({24'd0, b} << (8 * (r - CRC_BEFORE_AT)));
            else if (r >= CRC_AFTER_AT && r < NAME_FIELD_AT)
                crc_post_st = crc_post_st | ({24'd0, b} << (8 * (r - CRC_AFTER_AT)));
            else if (r >= NAME_FIELD_AT && r < NAME_FIELD_AT + NAME_FIELD_LEN
                     && r - NAME_FIELD_AT < NAME_BYTES)
                rec_name[r - NAME_FIELD_AT] = b;
            if (r >= REC_LAST)
            begin
                phase   = PH_AFTER;
                crc_run = '0;
            end
        end
        else if ({15'd0, pos} < len_st)
        begin
            crc_run = crc_step(crc_run, b);
        end
        pos = pos + 17'd1;
    endtask

    function automatic status_t judge_image(input logic active, input logic pending,
                                            input logic raw);
        int n;
        if (active)
            return ST_UPDATING;
        if (pending)
            return ST_PENDING;
        if (phase == PH_SEARCH || rec_off[1:0] != 2'd0)
            return ST_NO_SIG;
        if (phase != PH_AFTER || len_st > REGION_BYTES
            || {1'b0, len_st} < {16'd0, rec_off} + 33'(REC_BYTES)
            || len_st > {15'd0, pos})
            return ST_BAD_LENGTH;
        n = exp_name_len;
        if (n > 8)
            n = 8;
        if (n > NAME_BYTES)
            n = NAME_BYTES;
        for (int i = 0; i < n; i++)
        begin
            if (exp_name[8*i +: 8] != rec_name[i])
                return ST_BOARD;
        end
        if (crc_pre != crc_pre_st || crc_run != crc_post_st)
            return ST_CRC;
        if (!raw)
            return ST_NO_RAW;
        return ST_OK;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        status_t st;
        if (!rst_n)
        begin
            restart_scan();
            exp_name     = '0;
            exp_name_len = '0;
            pending_verdicts.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BOARD_NAME:     exp_name = cfg_data;
                    CFG_BOARD_NAME_LEN: exp_name_len = cfg_data[NAME_LEN_W-1:0];
                    default: ;
                endcase
            end
            if (item_valid && item_ready)
            begin
                // bytes past the region are dropped, last still closes the image
                if (pos < REGION_BYTES)
                    absorb_byte(item.image_byte);
                if (item.last)
                begin
                    st           = judge_image(item.update_active, item.update_pending,
                                               item.raw_command_seen);
                    want.boot_ok = (st == ST_OK);
                    want.status  = st;
                    pending_verdicts.push_back(want);
                    restart_scan();
                end
            end
            if (result_valid && result_ready)
            begin
                got = result;
                if (pending_verdicts.size() == 0)
                begin
                    $error("verdict beat with none due: boot_ok %0b status %0d",
                           got.boot_ok, got.status);
                    errors++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (got.boot_ok !== want.boot_ok)
                    begin
                        $error("boot_ok expected %0b actual %0b", want.boot_ok, got.boot_ok);
                        errors++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, got.status);
                        errors++;
                    end
                end
            end
        end
        mismatches   <= errors;
        verdicts_due <= pending_verdicts.size();
    end

endmodule

/* verif/tb_boot_image_signature_verifier.sv */
`timescale 1ns / 100ps

module tb_boot_image_signature_verifier;
    import bisv_pkg::*;

    localparam int REGION_BYTES    = 112640;
    localparam int STALL_LIMIT     = 4000;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int BEATS_PER_PHASE = 240;
    localparam int IMAGES_PER_PHASE = 4;

    typedef enum int {
        FLAW_NONE,
        FLAW_NOISE,
        FLAW_CRC_PRE,
        FLAW_CRC_POST,
        FLAW_NAME,
        FLAW_LEN_SHORT,
        FLAW_LEN_LONG,
        FLAW_LEN_REGION,
        FLAW_MISALIGN,
        FLAW_NO_MAGIC,
        FLAW_TRUNC
    } flaw_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    item_t                 item;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    verdicts_due;

    logic [7:0]  img [$];
    logic [63:0] board_id = '0;
    int          burst_left = 0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_hold_req = 1'b0;
    bit          rx_hold_done = 1'b0;
    int          quiet = 0;

    always #2 clk = ~clk;

    boot_image_signature_verifier i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bisv_verdict_checker #(
        .REGION_BYTES (REGION_BYTES)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .verdicts_due (verdicts_due)
    );

    // CRC for building well-formed records
    function automatic logic [31:0] sum_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] s;
        s = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (s[0])
                s = (s >> 1) ^ CRC_POLY;
            else
                s = s >> 1;
        end
        return s;
    endfunction

    task automatic build_image(input flaw_t flaw, input int pre_len, input int post_len,
                               input int tail_len);
        logic [31:0] c_pre;
        logic [31:0] c_post;
        logic [31:0] stated_len;
        logic [7:0]  b;
        int          rec_at;
        int          at;
        int          cut;
        img.delete();
        if (flaw == FLAW_NOISE)
        begin
            for (int i = 0; i < pre_len; i++)
            begin
                img.push_back(8'($urandom));
            end
            return;
        end
        if (flaw == FLAW_MISALIGN && pre_len % 4 == 0)
            pre_len += $urandom_range(1, 3);
        c_pre = '0;
        for (int i = 0; i < pre_len; i++)
        begin
            b = 8'($urandom);
            img.push_back(b);
            c_pre = sum_byte(c_pre, b);
        end
        rec_at = img.size();
        for (int i = 0; i < 8; i++)
        begin
            img.push_back(MAGIC_SEQ[8*i +: 8]);
        end
        repeat (12)
        begin
            img.push_back(8'h00);
        end
        for (int i = 0; i < 8; i++)
        begin
            img.push_back(board_id[8*i +: 8]);
        end
        repeat (20)
        begin
            img.push_back(8'($urandom));
        end
        for (int i = 0; i < post_len; i++)
        begin
            img.push_back(8'($urandom));
        end
        // a later marker copy must not restart the search
        if (post_len >= 8 && $urandom_range(0, 5) == 0)
        begin
            at = rec_at + 48 + $urandom_range(0, post_len - 8);
            for (int i = 0; i < 8; i++)
            begin
                img[at + i] = MAGIC_SEQ[8*i +: 8];
            end
        end
        c_post = '0;
        for (int i = 0; i < post_len; i++)
        begin
            c_post = sum_byte(c_post, img[rec_at + 48 + i]);
        end
        for (int i = 0; i < tail_len; i++)
        begin
            img.push_back(8'($urandom));
        end
        stated_len = pre_len + 48 + post_len;
        case (flaw)
            FLAW_CRC_PRE:    c_pre ^= 32'd1 << $urandom_range(0, 31);
            FLAW_CRC_POST:   c_post ^= 32'd1 << $urandom_range(0, 31);
            FLAW_NAME:       img[rec_at + NAME_FIELD_AT + $urandom_range(0, 7)] ^=
                                 8'(1 << $urandom_range(0, 7));
            FLAW_LEN_SHORT:  stated_len = $urandom_range(0, pre_len + 47);
            FLAW_LEN_LONG:   stated_len = img.size() + $urandom_range(1, 16);
            FLAW_LEN_REGION: stated_len = $urandom_range(0, 1) ? REGION_BYTES + 1
                                                               : ($urandom | 32'h8000_0000);
            FLAW_NO_MAGIC:   img[rec_at + $urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
            default: ;
        endcase
        for (int k = 0; k < 4; k++)
        begin
            img[rec_at + LEN_AT + k]        = stated_len[8*k +: 8];
            img[rec_at + CRC_BEFORE_AT + k] = c_pre[8*k +: 8];
            img[rec_at + CRC_AFTER_AT + k]  = c_post[8*k +: 8];
        end
        if (flaw == FLAW_TRUNC)
        begin
            cut = rec_at + $urandom_range(1, 47);
            while (img.size() > cut)
            begin
                void'(img.pop_back());
            end
        end
    endtask

    // drive at the edge, hold until taken; gaps come between bursts
    task automatic push_beat(input item_t b);
        item       <= b;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (tx_gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic send_image(input bit act, input bit pend, input bit raw);
        item_t b;
        for (int i = 0; i < img.size(); i++)
        begin
            b.image_byte = img[i];
            b.last       = (i == img.size() - 1);
            if (b.last)
            begin
                b.update_active    = act;
                b.update_pending   = pend;
                b.raw_command_seen = raw;
            end
            else
            begin
                b.update_active    = 1'($urandom_range(0, 1));
                b.update_pending   = 1'($urandom_range(0, 1));
                b.raw_command_seen = 1'($urandom_range(0, 1));
            end
            push_beat(b);
        end
    endtask

    task automatic send_lone(input logic [7:0] b, input bit act, input bit pend, input bit raw);
        img.delete();
        img.push_back(b);
        send_image(act, pend, raw);
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (verdicts_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_board(input logic [63:0] name, input logic [NAME_LEN_W-1:0] len);
        cfg_index <= CFG_BOARD_NAME;
        cfg_data  <= name;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_BOARD_NAME_LEN;
        cfg_data  <= CFG_DATA_W'(len);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        board_id = name;
    endtask

    // result side: stall modes of random span, plus one long hold-off
    initial
    begin
        int mode;
        int span_left;
        mode = 0;
        span_left = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req && !rx_hold_done)
            begin
                result_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_done = 1'b1;
                result_ready <= 1'b1;
            end
            else
            begin
                if (span_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    span_left = $urandom_range(8, 64);
                end
                span_left--;
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= 1'($urandom_range(0, 1));
                    default: result_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [63:0]           names [4];
        logic [NAME_LEN_W-1:0] lens [4];
        flaw_t                 kind;
        int                    phase_beats;
        int                    phase_images;
        int                    pick;
        names[0] = {$urandom, $urandom};
        lens[0]  = 4'd8;
        names[1] = '1;
        lens[1]  = '1;
        names[2] = '0;
        lens[2]  = '0;
        names[3] = {$urandom, $urandom};
        lens[3]  = 4'($urandom_range(1, 7));

        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_BOARD_NAME;
        cfg_data   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: flag priority and the smallest image, on reset registers
        send_lone(8'h00, 1'b1, 1'b0, 1'b0);
        send_lone(8'hFF, 1'b1, 1'b1, 1'b1);
        send_lone(8'h5A, 1'b0, 1'b1, 1'b0);
        send_lone(8'hA5, 1'b0, 1'b0, 1'b1);
        build_image(FLAW_NONE, 0, 0, 0);
        send_image(1'b0, 1'b0, 1'b1);
        settle();
        set_board(names[0], lens[0]);
        build_image(FLAW_NONE, 4, 5, 3);
        send_image(1'b0, 1'b0, 1'b1);
        build_image(FLAW_NONE, 8, 2, 0);
        send_image(1'b0, 1'b0, 1'b0);
        for (int f = FLAW_CRC_PRE; f <= FLAW_TRUNC; f++)
        begin
            build_image(flaw_t'(f), 4, 6, 2);
            send_image(1'b0, 1'b0, 1'b1);
        end

        for (int p = 0; p < 4; p++)
        begin
            settle();
            set_board(names[p], lens[p]);
            if (p == 0)
                rx_hold_req = 1'b1;
            tx_gaps_on   = (p != 2);
            phase_beats  = 0;
            phase_images = 0;
            while (phase_beats < BEATS_PER_PHASE || phase_images < IMAGES_PER_PHASE)
            begin
                pick = $urandom_range(0, 9);
                kind = FLAW_NONE;
                if (pick >= 7)
                    kind = FLAW_NOISE;
                else if (pick >= 5)
                    kind = flaw_t'($urandom_range(FLAW_CRC_PRE, FLAW_TRUNC));
                if (kind == FLAW_NOISE)
                    build_image(kind, $urandom_range(1, 16), 0, 0);
                else
                    build_image(kind, 4 * $urandom_range(0, 6), $urandom_range(0, 24),
                                $urandom_range(0, 6));
                phase_beats += img.size();
                phase_images++;
                send_image($urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0,
                           $urandom_range(0, 9) != 0);
            end
        end

        settle();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* boot_image_signature_verifier.f */
rtl/core/bisv_pkg.sv
rtl/core/bisv_scan.sv
rtl/core/boot_image_signature_verifier.sv
verif/bisv_verdict_checker.sv
verif/tb_boot_image_signature_verifier.sv
